/* hw/rtl/cau_pkg.sv */
`default_nettype none
package cau_pkg;

  localparam int unsigned DW    = 16;        // operand / result width
  localparam int unsigned FB    = 8;         // fraction bits
  localparam int unsigned NSTEP = DW + 1;    // quotient / root bits, one cell each
  localparam int unsigned PW    = 2 * DW;    // product width
  localparam int unsigned MW    = 2 * DW + 1; // magnitude width
  localparam int unsigned RW    = 3 * DW + 1; // divider remainder width
  localparam int unsigned SRW   = PW + 2;    // root trial width
  localparam int unsigned QW    = DW + 1;    // quotient / root width

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_CONJ = 3'd4;
  localparam logic [2:0] MODE_MOD  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [2:0]           mode;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic [1:0]           status;
    logic                 equal;
  } res_t;

  // state carried along the cell row
  typedef struct packed {
    logic [2:0]    mode;
    logic          eq;
    logic          dz;
    logic          ovf_re;
    logic          ovf_im;
    logic          neg_re;
    logic          neg_im;
    logic [PW-1:0] den;
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [PW-1:0] srem;
    logic [QW-1:0] root;
    logic [DW-1:0] fix_re;
    logic [DW-1:0] fix_im;
    logic          fix_sat;
  } cell_t;

  function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] v);
    logic [MW-1:0] r;
    r = v[MW-1] ? MW'(-v) : MW'(v);
    return r;
  endfunction

  // {saturated, value} of a sign-magnitude number
  function automatic logic [DW:0] sat_fn(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] lim;
    logic [DW:0]   r;
    lim = MW'(1) << (DW - 1);
    if (neg) begin
      if (mag > lim) r = {1'b1, lim[DW-1:0]};
      else           r = {1'b0, DW'(~mag + MW'(1))};
    end else begin
      if (mag > lim - MW'(1)) r = {1'b1, DW'(lim - MW'(1))};
      else                    r = {1'b0, mag[DW-1:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cau_cell.sv */
`default_nettype none
module cau_cell import cau_pkg::*; #(
  parameter int unsigned J = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire cell_t c_i,
  output logic       valid_o,
  output cell_t      c_o
);

  logic  valid_q;
  cell_t c_d, c_q;
  logic [RW-1:0]  dtr;
  logic [SRW-1:0] strial;

  // one restoring step of both quotients and of the root, bit J
  always_comb begin
    c_d    = c_i;
    dtr    = RW'(c_i.den) << J;
    strial = (SRW'(c_i.root) << (J + 1)) + (SRW'(1) << (2 * J));
    if (c_i.rem_re >= dtr) begin
      c_d.rem_re  = c_i.rem_re - dtr;
      c_d.q_re[J] = 1'b1;
    end
    if (c_i.rem_im >= dtr) begin
      c_d.rem_im  = c_i.rem_im - dtr;
      c_d.q_im[J] = 1'b1;
    end
    if (SRW'(c_i.srem) >= strial) begin
      c_d.srem    = PW'(SRW'(c_i.srem) - strial);
      c_d.root[J] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  assign valid_o = valid_q;
  assign c_o     = c_q;

endmodule
`default_nettype wire

/* hw/rtl/complex_arith_unit_core.sv */
`default_nettype none
// Complex-number ALU on signed Q8.8 operands.
// Request channel: req_i carries mode and operands a, b; a request is taken
// at a rising edge with start_i high and busy_o low. busy_o is always low:
// a new request can be taken every cycle.
// Result channel: res_o is valid for exactly one cycle while done_o is high;
// the receiver cannot stall it, so results must be taken when shown.
// Throughput: one request per cycle.
// Stages: operand products (one 16x16 multiplier per product), then sums,
// rounding, magnitudes and divider overflow check, then a row of 17 cells
// that each settle one quotient bit of both divisions and one root bit of
// the modulus, then sign and saturation into the output register.
// The cell row sets the latency: one cell per quotient bit.
// Add, subtract, multiply and conjugate finish before the row and ride
// through it unchanged. Divide by zero gives 0 with status 1; saturation
// gives status 2.
// Reset clears all valid flags; requests in flight are dropped.
module complex_arith_unit_core import cau_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  input  wire req_t req_i,
  output logic      done_o,
  output res_t      res_o
);

  localparam int unsigned LAT = NSTEP + 3;

  // stage 1: products
  logic                 v1_q;
  req_t                 r1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q;
  logic signed [PW-1:0] p_br2_q, p_bi2_q, p_ar2_q, p_ai2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q    <= req_i;
    p_rr_q  <= PW'(req_i.a_re) * PW'(req_i.b_re);
    p_ii_q  <= PW'(req_i.a_im) * PW'(req_i.b_im);
    p_ir_q  <= PW'(req_i.a_im) * PW'(req_i.b_re);
    p_ri_q  <= PW'(req_i.a_re) * PW'(req_i.b_im);
    p_br2_q <= PW'(req_i.b_re) * PW'(req_i.b_re);
    p_bi2_q <= PW'(req_i.b_im) * PW'(req_i.b_im);
    p_ar2_q <= PW'(req_i.a_re) * PW'(req_i.a_re);
    p_ai2_q <= PW'(req_i.a_im) * PW'(req_i.a_im);
  end

  // stage 2: setup of the cell row
  logic signed [PW:0] nr, ni, xm, ym;
  logic signed [DW:0] s_re, s_im;
  logic [MW-1:0]      nmag_re, nmag_im, half, rmag_re, rmag_im;
  logic [PW-1:0]      den, sq;
  logic [RW-1:0]      lim_n;
  logic [DW:0]        sr_re, sr_im;
  cell_t              c0_d;

  always_comb begin
    nr    = (PW + 1)'(p_rr_q) + (PW + 1)'(p_ii_q);
    ni    = (PW + 1)'(p_ir_q) - (PW + 1)'(p_ri_q);
    xm    = (PW + 1)'(p_rr_q) - (PW + 1)'(p_ii_q);
    ym    = (PW + 1)'(p_ir_q) + (PW + 1)'(p_ri_q);
    den   = PW'($unsigned(p_br2_q)) + PW'($unsigned(p_bi2_q));
    sq    = PW'($unsigned(p_ar2_q)) + PW'($unsigned(p_ai2_q));
    half  = MW'((2 ** FB) >> 1);
    nmag_re = mag_of(MW'(nr));
    nmag_im = mag_of(MW'(ni));
    lim_n = RW'(den) << (DW + 1);
    s_re  = '0;
    s_im  = '0;
    sr_re = '0;
    sr_im = '0;
    rmag_re = '0;
    rmag_im = '0;

    c0_d         = '0;
    c0_d.mode    = r1_q.mode;
    c0_d.eq      = (r1_q.a_re == r1_q.b_re) && (r1_q.a_im == r1_q.b_im);
    c0_d.dz      = (r1_q.b_re == '0) && (r1_q.b_im == '0);
    c0_d.den     = den;
    c0_d.rem_re  = RW'(nmag_re) << FB;
    c0_d.rem_im  = RW'(nmag_im) << FB;
    c0_d.ovf_re  = (RW'(nmag_re) << FB) >= lim_n;
    c0_d.ovf_im  = (RW'(nmag_im) << FB) >= lim_n;
    c0_d.neg_re  = nr[PW];
    c0_d.neg_im  = ni[PW];
    c0_d.srem    = sq;

    case (r1_q.mode)
      MODE_ADD, MODE_SUB: begin
        if (r1_q.mode == MODE_ADD) begin
          s_re = (DW + 1)'(r1_q.a_re) + (DW + 1)'(r1_q.b_re);
          s_im = (DW + 1)'(r1_q.a_im) + (DW + 1)'(r1_q.b_im);
        end else begin
          s_re = (DW + 1)'(r1_q.a_re) - (DW + 1)'(r1_q.b_re);
          s_im = (DW + 1)'(r1_q.a_im) - (DW + 1)'(r1_q.b_im);
        end
        sr_re = sat_fn(s_re[DW], mag_of(MW'(s_re)));
        sr_im = sat_fn(s_im[DW], mag_of(MW'(s_im)));
      end
      MODE_MUL: begin
        // round to nearest, ties away from zero, on the magnitude
        rmag_re = (mag_of(MW'(xm)) + half) >> FB;
        rmag_im = (mag_of(MW'(ym)) + half) >> FB;
        sr_re   = sat_fn(xm[PW], rmag_re);
        sr_im   = sat_fn(ym[PW], rmag_im);
      end
      MODE_CONJ: begin
        sr_re = {1'b0, r1_q.a_re};
        sr_im = sat_fn(!r1_q.a_im[DW-1], mag_of(MW'(r1_q.a_im)));
      end
      default: begin
      end
    endcase
    c0_d.fix_re  = sr_re[DW-1:0];
    c0_d.fix_im  = sr_im[DW-1:0];
    c0_d.fix_sat = sr_re[DW] || sr_im[DW];
  end

  logic  v_c [NSTEP+1];
  cell_t c_c [NSTEP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_c[0] <= 1'b0;
    end else begin
      v_c[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_c[0] <= c0_d;
  end

  // cell row: cell k settles bit DW-k
  for (genvar k = 0; k < NSTEP; k++) begin : g_cell
    cau_cell #(
      .J(DW - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v_c[k]),
      .c_i    (c_c[k]),
      .valid_o(v_c[k+1]),
      .c_o    (c_c[k+1])
    );
  end

  // final stage: sign, saturation, status
  cell_t         cf;
  logic [DW:0]   fr_re, fr_im;
  logic [MW-1:0] big;
  res_t          res_d, res_q;
  logic          done_q;
  logic          sat;

  always_comb begin
    cf    = c_c[NSTEP];
    big   = MW'(1) << DW;
    fr_re = '0;
    fr_im = '0;
    sat   = 1'b0;
    res_d = '0;
    case (cf.mode)
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_CONJ: begin
        fr_re = {1'b0, cf.fix_re};
        fr_im = {1'b0, cf.fix_im};
        sat   = cf.fix_sat;
      end
      MODE_DIV: begin
        if (!cf.dz) begin
          fr_re = sat_fn(cf.neg_re, cf.ovf_re ? big : MW'(cf.q_re));
          fr_im = sat_fn(cf.neg_im, cf.ovf_im ? big : MW'(cf.q_im));
          sat   = fr_re[DW] || fr_im[DW];
        end
      end
      MODE_MOD: begin
        fr_re = sat_fn(1'b0, MW'(cf.root));
        sat   = fr_re[DW];
      end
      default: begin
      end
    endcase
    res_d.res_re = fr_re[DW-1:0];
    res_d.res_im = fr_im[DW-1:0];
    res_d.equal  = cf.eq;
    if (cf.mode == MODE_DIV && cf.dz) res_d.status = ST_DIV0;
    else if (sat)                     res_d.status = ST_SAT;
    else                              res_d.status = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_c[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without request");
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_DIV0) |-> (res_o.res_re == '0 && res_o.res_im == '0))
    else $error("divide by zero result not zero");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.status == ST_OK || res_o.status == ST_DIV0 ||
                res_o.status == ST_SAT))
    else $error("bad status code");
`endif

endmodule
`default_nettype wire

/* tb/tb_complex_arith_unit_core.sv */
`default_nettype none
module tb_complex_arith_unit_core;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected-result store and checker for the complex ALU.
  class cau_scoreboard;
    res_t pending_q[$];
    int   n_err;

    function new();
      n_err = 0;
    endfunction

    // Saturate a signed value to the 16-bit range; flags on clip.
    static function logic [15:0] clip16(input longint v, inout bit sat);
      if (v > 32767) begin
        sat = 1;
        return 16'sh7fff;
      end
      if (v < -32768) begin
        sat = 1;
        return 16'sh8000;
      end
      return v[15:0];
    endfunction

    // Round to nearest, ties away from zero, dropping FB bits.
    static function longint round_fb(input longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
      return (v < 0) ? -m : m;
    endfunction

    // Quotient with FB fraction bits, truncated toward zero, capped like the unit.
    static function longint quot_fb(input longint n, input longint den);
      longint m, q, r;
      m = (n < 0) ? -n : n;
      q = m / den;
      r = m % den;
      if (q > 65536) q = 65536;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r -= den;
          q |= 1;
        end
      end
      return (n < 0) ? -q : q;
    endfunction

    static function longint isqrt(input longint x);
      longint r;
      r = 0;
      for (int b = 20; b >= 0; b--)
        if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= x) r += (64'sd1 << b);
      return r;
    endfunction

    function void note_request(input req_t rq);
      res_t   e;
      bit     sat;
      longint ar, ai, br, bi, den;
      ar = rq.a_re; ai = rq.a_im; br = rq.b_re; bi = rq.b_im;
      sat = 0;
      e = '0;
      case (rq.mode)
        MODE_ADD: begin
          e.res_re = clip16(ar + br, sat);
          e.res_im = clip16(ai + bi, sat);
        end
        MODE_SUB: begin
          e.res_re = clip16(ar - br, sat);
          e.res_im = clip16(ai - bi, sat);
        end
        MODE_MUL: begin
          e.res_re = clip16(round_fb(ar * br - ai * bi), sat);
          e.res_im = clip16(round_fb(ai * br + ar * bi), sat);
        end
        MODE_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) e.status = ST_DIV0;
          else begin
            e.res_re = clip16(quot_fb(ar * br + ai * bi, den), sat);
            e.res_im = clip16(quot_fb(ai * br - ar * bi, den), sat);
          end
        end
        MODE_CONJ: begin
          e.res_re = rq.a_re;
          e.res_im = clip16(-ai, sat);
        end
        MODE_MOD: e.res_re = clip16(isqrt(ar * ar + ai * ai), sat);
        default: ;
      endcase
      if (e.status == ST_OK && sat) e.status = ST_SAT;
      e.equal = (ar == br) && (ai == bi);
      pending_q.push_back(e);
    endfunction

    function void check_result(input res_t got);
      res_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", got);
        n_err++;
        return;
      end
      e = pending_q.pop_front();
      if (got.res_re !== e.res_re) begin
        $error("res_re exp %h got %h", e.res_re, got.res_re); n_err++;
      end
      if (got.res_im !== e.res_im) begin
        $error("res_im exp %h got %h", e.res_im, got.res_im); n_err++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); n_err++;
      end
      if (got.equal !== e.equal) begin
        $error("equal exp %0d got %0d", e.equal, got.equal); n_err++;
      end
    endfunction
  endclass

  localparam int LATENCY   = 20;
  localparam int N_RANDOM  = 1650;
  localparam longint LIMIT = 200000;

  logic clk_i, rst_ni, start_i, busy_o, done_o;
  req_t req_i;
  res_t res_o;
  cau_scoreboard sb;
  bit     quiet;   // no idling while set
  longint cycle_cnt;

  complex_arith_unit_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .res_o
  );

  always begin
    clk_i = 1'b0; #2;
    clk_i = 1'b1; #2;
  end

  // Sample results and accepted requests at each rising edge.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if (start_i && !busy_o) sb.note_request(req_i);
    end
    if (cycle_cnt > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request, with random idle cycles ahead of it; start_i stays
  // high across back-to-back requests.
  task automatic send_request(input req_t rq);
    while (!quiet && $urandom_range(99) < 37) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(1024)) - 512);
      3: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    req_t rq;
    logic [15:0] edges[5];
    sb = new();
    cycle_cnt = 0;
    quiet = 0;
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes in every mode, including unused codes, divide by
    // zero, conjugate of the most negative imaginary part and a == b.
    edges = '{16'h8000, 16'h7fff, 16'h0000, 16'h0100, 16'hff00};
    for (int m = 0; m < 8; m++) begin
      rq.mode = 3'(m);
      rq.a_re = edges[m % 5]; rq.a_im = 16'h8000;
      rq.b_re = (m == MODE_DIV) ? 16'h0 : 16'h7fff;
      rq.b_im = (m == MODE_DIV) ? 16'h0 : edges[(m + 2) % 5];
      send_request(rq);
    end
    for (int k = 0; k < 5; k++) begin
      rq.mode = (k < 3) ? MODE_MUL : MODE_DIV;
      rq.a_re = edges[k]; rq.a_im = edges[(k + 1) % 5];
      rq.b_re = edges[k]; rq.b_im = edges[(k + 1) % 5];
      send_request(rq);
    end
    rq = '{mode: MODE_DIV, a_re: 16'h7fff, a_im: 16'h7fff, b_re: 16'h0001, b_im: 16'h0};
    send_request(rq);
    rq = '{mode: MODE_MOD, a_re: 16'h8000, a_im: 16'h8000, b_re: 16'h0, b_im: 16'h0};
    send_request(rq);

    // Random: mostly the six real modes, a few unused codes; one stretch
    // runs with no idle cycles at all.
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 600 && n < 800);
      rq.mode = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      rq.a_re = rand_operand();
      rq.a_im = rand_operand();
      if ($urandom_range(9) == 0) begin
        rq.b_re = rq.a_re; rq.b_im = rq.a_im;
      end else begin
        rq.b_re = rand_operand(); rq.b_im = rand_operand();
      end
      send_request(rq);
    end
    start_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (sb.n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/cau_pkg.sv
hw/rtl/cau_cell.sv
hw/rtl/complex_arith_unit_core.sv
tb/tb_complex_arith_unit_core.sv
